### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the min tracking stack
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on clk_i, masked while rst_ni is low
`define MSTK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on clk_i at every edge, reset included
`define MSTK_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### rtl/core/mstk_pkg.sv
// ----------------------------------------------------------------------------
// mstk_pkg
// types and constants shared by the min tracking stack modules
// ----------------------------------------------------------------------------
package mstk_pkg;

  localparam int DefaultDepth = 8;
  localparam int DataW        = 32;
  localparam int EntryW       = 34;
  localparam int StatusW      = 2;
  localparam int CountW       = 4;

  localparam logic signed [DataW-1:0] MinReset = 32'sh7fff_ffff;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_REPLY
  } state_e;

  typedef struct packed {
    logic exec;
    logic load_top;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic need_load;
  } sts_t;

endpackage

### rtl/core/mstk_ram.sv
// ----------------------------------------------------------------------------
// mstk_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module mstk_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 8,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/core/mstk_ctrl.sv
// ----------------------------------------------------------------------------
// mstk_ctrl
// sequencer for the min tracking stack: accept, refill top, reply
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mstk_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  mstk_pkg::sts_t sts_i,
  output mstk_pkg::cmd_t cmd_o
);
  import mstk_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = sts_i.need_load ? S_LOAD : S_REPLY;
        end
      end
      S_LOAD: begin
        state_d = S_REPLY;
      end
      S_REPLY: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.exec = in_valid_i;
      end
      S_LOAD: begin
        cmd_o.load_top = 1'b1;
      end
      S_REPLY: begin
        cmd_o.out_load = out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `MSTK_ASSERT(a_load_then_reply, (state_q == S_LOAD) |=> (state_q == S_REPLY),
               "top refill not followed by reply")
  `MSTK_ASSERT(a_result_held, (out_valid_q && out_stall_i) |=> out_valid_q,
               "stalled result dropped")
  `MSTK_ASSERT_ALWAYS(a_one_cmd, $onehot0({cmd_o.exec, cmd_o.load_top, cmd_o.out_load}),
                      "more than one datapath command")

endmodule

### rtl/core/mstk_datapath.sv
// ----------------------------------------------------------------------------
// mstk_datapath
// entry store, fill level, running minimum and result registers
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mstk_datapath #(
  parameter int DEPTH = mstk_pkg::DefaultDepth
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mstk_pkg::cmd_t                      cmd_i,
  output mstk_pkg::sts_t                      sts_o,
  input  logic                                operation_i,
  input  logic signed [mstk_pkg::DataW-1:0]   push_value_i,
  output logic [mstk_pkg::StatusW-1:0]        status_o,
  output logic signed [mstk_pkg::DataW-1:0]   top_value_o,
  output logic signed [mstk_pkg::DataW-1:0]   min_value_o,
  output logic [mstk_pkg::CountW-1:0]         entry_count_o,
  output logic                                is_empty_o
);
  import mstk_pkg::*;

  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FillW = $clog2(DEPTH + 1);

  logic [FillW-1:0]             fill_q, fill_d;
  logic signed [DataW-1:0]      min_q, min_d;
  logic signed [EntryW-1:0]     top_q, top_d;
  status_e                      status_q, status_d;

  logic signed [EntryW-1:0]     val_ext, min_ext, enc_val, restored;
  logic                         is_push, full, empty;
  logic                         wr_en;
  logic [AddrW-1:0]             wr_addr, rd_addr;
  logic [FillW:0]               fill_m2;
  logic [EntryW-1:0]            rd_data;

  logic [StatusW-1:0]           res_status_q;
  logic signed [DataW-1:0]      res_top_q, res_min_q;
  logic [CountW-1:0]            res_count_q;
  logic                         res_empty_q;

  assign is_push  = (op_e'(operation_i) == OP_PUSH);
  assign full     = (fill_q == FillW'(DEPTH));
  assign empty    = (fill_q == '0);
  assign val_ext  = EntryW'(push_value_i);
  assign min_ext  = EntryW'(min_q);
  assign enc_val  = (val_ext <<< 1) - min_ext;
  assign restored = (min_ext <<< 1) - top_q;
  assign fill_m2  = {1'b0, fill_q} - (FillW + 1)'(2);
  assign wr_addr  = fill_q[AddrW-1:0];
  assign rd_addr  = fill_m2[AddrW-1:0];

  assign sts_o.need_load = !is_push && (fill_q > FillW'(1));

  always_comb begin
    fill_d   = fill_q;
    min_d    = min_q;
    top_d    = top_q;
    status_d = status_q;
    wr_en    = 1'b0;
    if (cmd_i.exec) begin
      status_d = ST_OK;
      if (is_push) begin
        if (full) begin
          status_d = ST_OVERFLOW;
        end else begin
          wr_en  = 1'b1;
          fill_d = fill_q + 1'b1;
          if (empty) begin
            top_d = val_ext;
            min_d = push_value_i;
          end else if (push_value_i < min_q) begin
            top_d = enc_val;
            min_d = push_value_i;
          end else begin
            top_d = val_ext;
          end
        end
      end else begin
        if (empty) begin
          status_d = ST_UNDERFLOW;
        end else begin
          fill_d = fill_q - 1'b1;
          if (top_q <= min_ext) begin
            min_d = restored[DataW-1:0];
          end
        end
      end
    end else if (cmd_i.load_top) begin
      top_d = rd_data;
    end
  end

  mstk_ram #(
    .WIDTH(EntryW),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(top_d),
    .rd_en_i  (cmd_i.exec && sts_o.need_load),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      min_q  <= MinReset;
    end else begin
      fill_q <= fill_d;
      min_q  <= min_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q    <= top_d;
    status_q <= status_d;
    if (cmd_i.out_load) begin
      res_status_q <= status_q;
      res_count_q  <= CountW'(fill_q);
      res_empty_q  <= empty;
      if (empty) begin
        res_top_q <= '0;
        res_min_q <= '0;
      end else begin
        res_top_q <= (top_q < min_ext) ? min_q : top_q[DataW-1:0];
        res_min_q <= min_q;
      end
    end
  end

  assign status_o      = res_status_q;
  assign top_value_o   = res_top_q;
  assign min_value_o   = res_min_q;
  assign entry_count_o = res_count_q;
  assign is_empty_o    = res_empty_q;

  `MSTK_ASSERT(a_fill_bound, fill_q <= FillW'(DEPTH), "fill level above depth")
  `MSTK_ASSERT(a_push_grows, (cmd_i.exec && is_push && !full) |=>
               (fill_q == $past(fill_q) + 1'b1), "push did not grow the stack")
  `MSTK_ASSERT(a_pop_shrinks, (cmd_i.exec && !is_push && !empty) |=>
               (fill_q == $past(fill_q) - 1'b1), "pop did not shrink the stack")

endmodule

### rtl/core/min_tracking_stack_unit.sv
// ----------------------------------------------------------------------------
// min_tracking_stack_unit
// bounded signed stack that reports its minimum after every push or pop
// ----------------------------------------------------------------------------
// Each transfer on the input is one push or pop and yields one result transfer
// with status, decoded top, minimum, count and empty flag. A push or a rejected
// operation goes through the reply state to the result; a pop that leaves
// entries goes through the load state first, for the registered read of the
// new top from the entry ram. The input stalls until the result sits in the
// output register, which then holds it for the downstream side.
module min_tracking_stack_unit #(
  parameter int DEPTH = mstk_pkg::DefaultDepth
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               operation_i,
  input  logic signed [mstk_pkg::DataW-1:0]  push_value_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [mstk_pkg::StatusW-1:0]       status_o,
  output logic signed [mstk_pkg::DataW-1:0]  top_value_o,
  output logic signed [mstk_pkg::DataW-1:0]  min_value_o,
  output logic [mstk_pkg::CountW-1:0]        entry_count_o,
  output logic                               is_empty_o
);
  import mstk_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mstk_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mstk_datapath #(
    .DEPTH(DEPTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .operation_i  (operation_i),
    .push_value_i (push_value_i),
    .status_o     (status_o),
    .top_value_o  (top_value_o),
    .min_value_o  (min_value_o),
    .entry_count_o(entry_count_o),
    .is_empty_o   (is_empty_o)
  );

endmodule
